>>> rtl/tte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned EXT_WIDTH   = (VALUE_WIDTH > OUT_WIDTH) ? VALUE_WIDTH : OUT_WIDTH;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned NUM_TOKENS  = 3;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] RADIX    = 8'd10;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD
  } alu_op_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ADD,
    A_ABSX,
    A_ABSY,
    A_LOOP,
    A_SIGN
  } alu_state_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_EVAL,
    ST_CALC,
    ST_PUSH
  } tte_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

>>> rtl/tte_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module tte_alu
  import tte_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire alu_req_t               req_i,
  input  wire logic [VALUE_WIDTH-1:0] x_i,
  input  wire logic [VALUE_WIDTH-1:0] y_i,
  output      alu_stat_t              stat_o,
  output      logic [VALUE_WIDTH-1:0] result_o
);

  alu_state_e             state_q, state_d;
  alu_op_e                op_q, op_d;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [VALUE_WIDTH-1:0] b_q, b_d;
  logic [VALUE_WIDTH-1:0] q_q, q_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic                   done_q, done_d;

  logic [VALUE_WIDTH:0]   add_a, add_b, add_sum;
  logic                   add_sub;
  logic [VALUE_WIDTH:0]   rem_shift;
  logic                   last_step;

  // shared adder / subtractor
  assign add_sum   = add_a + (add_b ^ {(VALUE_WIDTH + 1){add_sub}})
                   + {{VALUE_WIDTH{1'b0}}, add_sub};
  assign rem_shift = {a_q, q_q[VALUE_WIDTH-1]};
  assign last_step = (cnt_q == CNT_WIDTH'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_ADD, OP_SUB: state_d = A_ADD;
            OP_MUL:         state_d = A_LOOP;
            default:        state_d = A_ABSX;
          endcase
        end
      end
      A_ADD:  state_d = A_IDLE;
      A_ABSX: state_d = A_ABSY;
      A_ABSY: state_d = A_LOOP;
      A_LOOP: begin
        if (last_step) begin
          state_d = (op_q == OP_MUL) ? A_IDLE : A_SIGN;
        end
      end
      A_SIGN: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    q_d     = q_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          q_d   = x_i;
          b_d   = y_i;
          a_d   = '0;
          cnt_d = CNT_WIDTH'(VALUE_WIDTH);
        end
      end
      A_ADD: begin
        add_a   = {1'b0, q_q};
        add_b   = {1'b0, b_q};
        add_sub = (op_q == OP_SUB);
        a_d     = add_sum[VALUE_WIDTH-1:0];
        done_d  = 1'b1;
      end
      A_ABSX: begin
        add_b   = {1'b0, q_q};
        add_sub = q_q[VALUE_WIDTH-1];
        q_d     = add_sum[VALUE_WIDTH-1:0];
        neg_d   = (op_q == OP_DIV) ? (q_q[VALUE_WIDTH-1] ^ b_q[VALUE_WIDTH-1])
                                   : q_q[VALUE_WIDTH-1];
      end
      A_ABSY: begin
        add_b   = {1'b0, b_q};
        add_sub = b_q[VALUE_WIDTH-1];
        b_d     = add_sum[VALUE_WIDTH-1:0];
        a_d     = '0;
      end
      A_LOOP: begin
        cnt_d = cnt_q - CNT_WIDTH'(1);
        if (op_q == OP_MUL) begin
          // shift-add, multiplier bits msb first
          add_a = {1'b0, a_q[VALUE_WIDTH-2:0], 1'b0};
          add_b = q_q[VALUE_WIDTH-1] ? {1'b0, b_q} : '0;
          a_d   = add_sum[VALUE_WIDTH-1:0];
          q_d   = {q_q[VALUE_WIDTH-2:0], 1'b0};
          done_d = last_step;
        end else begin
          // restoring division step
          add_a   = rem_shift;
          add_b   = {1'b0, b_q};
          add_sub = 1'b1;
          a_d     = add_sum[VALUE_WIDTH] ? rem_shift[VALUE_WIDTH-1:0]
                                         : add_sum[VALUE_WIDTH-1:0];
          q_d     = {q_q[VALUE_WIDTH-2:0], ~add_sum[VALUE_WIDTH]};
        end
      end
      A_SIGN: begin
        add_b   = (op_q == OP_DIV) ? {1'b0, q_q} : {1'b0, a_q};
        add_sub = neg_q;
        a_d     = add_sum[VALUE_WIDTH-1:0];
        done_d  = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = (state_q != A_IDLE);
  assign stat_o.done = done_q;
  assign result_o    = a_q;

endmodule

`default_nettype wire

>>> rtl/three_token_expression_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// Evaluates one "x op y" style line fed as ASCII characters, one character per beat.
// Space-separated tokens are collected (first three only); on the beat flagged with
// line_end_i the first token with a non-digit lead picks the operator (+ - * / %)
// and the other two are the operands, as 32-bit wrapping decimal values. One
// result beat follows each line: -1 for an unknown or missing operator or a zero
// divisor. Ordinary characters are taken at one per cycle. After a line end the
// input stalls until the result is formed; the iterative arithmetic unit has a
// single shared adder and runs one multiplier or quotient bit per cycle, so * /
// and % stall the longest. A finished result waits in an output
// register, so the next line is taken while it is still pending; the next result
// holds the input until that register has been read.
module three_token_expression_evaluator
  import tte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        line_end_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic signed [OUT_WIDTH-1:0] value_o
);

  tte_state_e             state_q, state_d;
  logic [1:0]             count_q, count_d;
  logic                   inside_q, inside_d;
  logic [7:0]             lead_q [NUM_TOKENS];
  logic [7:0]             lead_d [NUM_TOKENS];
  logic [VALUE_WIDTH-1:0] val_q  [NUM_TOKENS];
  logic [VALUE_WIDTH-1:0] val_d  [NUM_TOKENS];
  logic [VALUE_WIDTH-1:0] res_q, res_d;
  logic [OUT_WIDTH-1:0]   out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   in_beat;
  logic [VALUE_WIDTH-1:0] digit;
  logic [1:0]             cur_idx;

  logic [7:0]             op_lead;
  logic [VALUE_WIDTH-1:0] opnd_x, opnd_y;
  logic                   no_op, bad_op;
  alu_op_e                op_sel;
  alu_req_t               alu_req;
  alu_stat_t              alu_stat;
  logic [VALUE_WIDTH-1:0] alu_res;
  logic signed [EXT_WIDTH-1:0] res_ext;
  logic                   out_load;

  assign in_ready_o = (state_q == ST_RUN);
  assign in_beat    = in_valid_i && in_ready_o;
  assign digit      = VALUE_WIDTH'(char_in_i) - VALUE_WIDTH'(CH_ZERO);
  assign cur_idx    = count_q - 2'd1;

  // operator pick
  always_comb begin
    op_lead = lead_q[0];
    opnd_x  = val_q[1];
    opnd_y  = val_q[2];
    no_op   = 1'b0;
    if (!is_digit(lead_q[0])) begin
      op_lead = lead_q[0];
    end else if (!is_digit(lead_q[1])) begin
      op_lead = lead_q[1];
      opnd_x  = val_q[0];
    end else if (!is_digit(lead_q[2])) begin
      op_lead = lead_q[2];
      opnd_x  = val_q[0];
      opnd_y  = val_q[1];
    end else begin
      no_op   = 1'b1;
    end
  end

  always_comb begin
    op_sel = OP_ADD;
    bad_op = 1'b0;
    unique case (op_lead)
      CH_PLUS:  op_sel = OP_ADD;
      CH_MINUS: op_sel = OP_SUB;
      CH_STAR:  op_sel = OP_MUL;
      CH_SLASH: op_sel = OP_DIV;
      CH_PCT:   op_sel = OP_MOD;
      default:  bad_op = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_beat && line_end_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (no_op || bad_op
            || (((op_sel == OP_DIV) || (op_sel == OP_MOD)) && (opnd_y == '0))) begin
          state_d = ST_PUSH;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (alu_stat.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // token and result datapath
  always_comb begin
    count_d     = count_q;
    inside_d    = inside_q;
    lead_d      = lead_q;
    val_d       = val_q;
    res_d       = res_q;
    alu_req     = '{start: 1'b0, op: op_sel};
    out_load    = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (in_beat) begin
          if (char_in_i == CH_SPACE) begin
            inside_d = 1'b0;
          end else if (inside_q) begin
            for (int i = 0; i < NUM_TOKENS; i++) begin
              if (cur_idx == 2'(i)) begin
                val_d[i] = (val_q[i] << 3) + (val_q[i] << 1) + digit;
              end
            end
          end else if (count_q < 2'(NUM_TOKENS)) begin
            for (int i = 0; i < NUM_TOKENS; i++) begin
              if (count_q == 2'(i)) begin
                lead_d[i] = char_in_i;
                val_d[i]  = digit;
              end
            end
            count_d  = count_q + 2'd1;
            inside_d = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        alu_req.start = (state_d == ST_CALC);
        res_d         = '1;
        count_d       = '0;
        inside_d      = 1'b0;
        for (int i = 0; i < NUM_TOKENS; i++) begin
          lead_d[i] = '0;
          val_d[i]  = '0;
        end
      end
      ST_CALC: begin
        if (alu_stat.done) begin
          res_d = alu_res;
        end
      end
      ST_PUSH: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign res_ext     = EXT_WIDTH'(signed'(res_q));
  assign out_d       = out_load ? res_ext[OUT_WIDTH-1:0] : out_q;
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  tte_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .x_i      (opnd_x),
    .y_i      (opnd_y),
    .stat_o   (alu_stat),
    .result_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      count_q     <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TOKENS; i++) begin
        lead_q[i] <= '0;
        val_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inside_q    <= inside_d;
      out_valid_q <= out_valid_d;
      lead_q      <= lead_d;
      val_q       <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(out_q);

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_stat.done |-> (state_q == ST_CALC))
    else $error("arithmetic unit finished outside calc");

  a_line_end_evals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && line_end_i) |=> (state_q == ST_EVAL))
    else $error("line end beat not evaluated");

  a_out_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_PUSH))
    else $error("result beat without push");

  a_calc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CALC) && !alu_stat.done) |-> alu_stat.busy)
    else $error("calc waits on idle arithmetic unit");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tte_pkg::*;

  localparam int unsigned RAND_CHARS  = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_ROWS    = 9;
  localparam logic [31:0] ERR_VALUE   = 32'hffff_ffff;
  localparam logic [31:0] MIN_VALUE   = 32'h8000_0000;

  typedef struct packed {
    logic [8*14-1:0] text;
    logic [3:0]      len;
    logic            known;
    logic [31:0]     value;
  } line_row_t;

  // the trailing slash token accumulates to -1, so this is min / -1
  localparam line_row_t LINE_TABLE [NUM_ROWS] = '{
    '{"/ 2147483648 /", 4'd14, 1'b1, MIN_VALUE},
    '{"%",              4'd1,  1'b1, ERR_VALUE},
    '{"1 2 3",          4'd5,  1'b1, ERR_VALUE},
    '{"1 2",            4'd3,  1'b1, ERR_VALUE},
    '{8'hff,            4'd1,  1'b1, ERR_VALUE},
    '{8'h00,            4'd1,  1'b1, ERR_VALUE},
    '{"+",              4'd1,  1'b1, 32'd0},
    '{"-",              4'd1,  1'b1, 32'd0},
    '{"4 * 9",          4'd5,  1'b0, 32'd0}
  };

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  char_in_i   = '0;
  logic                        line_end_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [OUT_WIDTH-1:0] value_o;

  three_token_expression_evaluator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_in_i   (char_in_i),
    .line_end_i  (line_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // token collector state
  logic [1:0]  tok_count = '0;
  logic        in_token  = 1'b0;
  logic [7:0]  tok_lead  [NUM_TOKENS] = '{default: '0};
  logic [31:0] tok_value [NUM_TOKENS] = '{default: '0};

  logic [31:0] line_results_q [$];

  int unsigned burst_left   = 0;
  int unsigned chars_sent   = 0;
  int unsigned lines_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned ready_mode   = 0;
  int unsigned mode_left    = 0;
  logic [31:0] wanted;

  function automatic logic [31:0] apply_op(input logic [7:0] op, input logic [31:0] x,
                                           input logic [31:0] y);
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    sx = x;
    sy = y;
    case (op)
      CH_PLUS:  return x + y;
      CH_MINUS: return x - y;
      CH_STAR:  return x * y;
      CH_SLASH: begin
        if (y == '0) return ERR_VALUE;
        if (x == MIN_VALUE && sy == -32'sd1) return MIN_VALUE;
        return sx / sy;
      end
      CH_PCT: begin
        if (y == '0) return ERR_VALUE;
        if (x == MIN_VALUE && sy == -32'sd1) return '0;
        return sx % sy;
      end
      default: return ERR_VALUE;
    endcase
  endfunction

  function automatic logic take_char(input logic [7:0] c, input logic last,
                                     output logic [31:0] result);
    logic [31:0] digit;
    digit  = {24'd0, c} - {24'd0, CH_ZERO};
    result = '0;
    if (c == CH_SPACE) begin
      in_token = 1'b0;
    end else if (in_token) begin
      tok_value[tok_count - 2'd1] = tok_value[tok_count - 2'd1] * RADIX + digit;
    end else if (tok_count < NUM_TOKENS) begin
      tok_lead[tok_count]  = c;
      tok_value[tok_count] = digit;
      tok_count++;
      in_token = 1'b1;
    end
    if (!last) return 1'b0;
    if (tok_lead[0] < CH_ZERO || tok_lead[0] > CH_NINE)
      result = apply_op(tok_lead[0], tok_value[1], tok_value[2]);
    else if (tok_lead[1] < CH_ZERO || tok_lead[1] > CH_NINE)
      result = apply_op(tok_lead[1], tok_value[0], tok_value[2]);
    else if (tok_lead[2] < CH_ZERO || tok_lead[2] > CH_NINE)
      result = apply_op(tok_lead[2], tok_value[0], tok_value[1]);
    else
      result = ERR_VALUE;
    tok_count = '0;
    in_token  = 1'b0;
    tok_lead  = '{default: '0};
    tok_value = '{default: '0};
    return 1'b1;
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic last, input logic known,
                           input logic [31:0] typed);
    logic [31:0] predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    line_end_i <= last;
    // hold the beat until accepted
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chars_sent++;
    if (take_char(c, last, predicted)) begin
      line_results_q.push_back(known ? typed : predicted);
      lines_sent++;
    end
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (line_results_q.size() != 0);
    burst_left = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (line_results_q.size() == 0) begin
        $error("value: expected nothing, actual %0d", value_o);
        error_count++;
      end else begin
        wanted = line_results_q.pop_front();
        if (value_o !== wanted) begin
          $error("value: expected %0d, actual %0d", $signed(wanted), value_o);
          error_count++;
        end
      end
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(5, 60);
    end
    mode_left--;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 4) == 0);
      default: out_ready_i <= 1'b0;
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    line_row_t   row;
    logic [7:0]  line_q [$];
    logic [7:0]  ops [5];
    int unsigned rand_start;
    int unsigned n_tok;
    int unsigned op_pos;
    int unsigned n_dig;
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = LINE_TABLE[r];
      for (int i = 0; i < row.len; i++)
        send_beat(row.text[8*(row.len-1-i) +: 8], i == row.len - 1, row.known, row.value);
    end
    wait_all_results();

    rand_start = chars_sent;
    while (chars_sent - rand_start < RAND_CHARS) begin
      line_q.delete();
      if ($urandom_range(0, 5) == 0) begin
        // noise line
        repeat ($urandom_range(1, 10))
          line_q.push_back(($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(0, 255)));
      end else begin
        n_tok  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 3;
        op_pos = $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) line_q.push_back(CH_SPACE);
        for (int t = 0; t < n_tok; t++) begin
          if (t > 0) repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
          if (t == op_pos) begin
            line_q.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                          : ops[$urandom_range(0, 4)]);
            if ($urandom_range(0, 9) == 0) line_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
            repeat (n_dig) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
        if ($urandom_range(0, 7) == 0) line_q.push_back(CH_SPACE);
      end
      foreach (line_q[i]) send_beat(line_q[i], i == line_q.size() - 1, 1'b0, '0);
      if ($urandom_range(0, 15) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (100) @(posedge clk_i);
    $display("run covered %0d characters in %0d lines, %0d results compared, %0d mismatches",
             chars_sent, lines_sent, results_seen, error_count);
    if (error_count == 0 && line_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tte_pkg.sv
rtl/tte_alu.sv
rtl/three_token_expression_evaluator.sv
dv/testbench.sv
